@@ hdl/longest_subarray_sum_divisible_defines.svh @@
// Assertion macros shared by the longest-run block.
`ifndef LONGEST_SUBARRAY_SUM_DIVISIBLE_DEFINES_SVH
`define LONGEST_SUBARRAY_SUM_DIVISIBLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define LSDIV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define LSDIV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/lsdiv_pkg.sv @@
// Shared constants and types for the longest-run block.
`timescale 1ns / 1ps
`default_nettype none
package lsdiv_pkg;

  // Table size and sequence length limit.
  localparam int RESIDUE_SLOTS = 1024;
  localparam int MAX_LEN       = 65536;

  // Field and state widths.
  localparam int VALUE_W = 32;
  localparam int MOD_W   = 11;
  localparam int RES_W   = $clog2(RESIDUE_SLOTS);
  localparam int LEN_W   = 17;
  localparam int FIRST_W = 16;
  localparam int STEP_W  = $clog2(VALUE_W);

  // Sequence tag kept beside each table entry; tag zero means never valid.
  localparam int TAG_W   = 8;
  localparam int ENTRY_W = TAG_W + FIRST_W;

  // Status of the bit-serial reduction unit.
  typedef struct packed {
    logic busy;
    logic done;
  } lsdiv_red_status_t;

endpackage
`default_nettype wire

@@ hdl/lsdiv_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsdiv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port: the old word is returned on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hdl/lsdiv_reducer.sv @@
// Bit-serial floor modulo of a 33-bit two's complement sum by a small divisor.
`timescale 1ns / 1ps
`default_nettype none
module lsdiv_reducer
  import lsdiv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W:0]   sum,
  input  wire logic [MOD_W-1:0]   divisor,
  output lsdiv_red_status_t       status,
  output logic      [RES_W-1:0]   residue
);

  logic [VALUE_W-1:0] shreg;
  logic [STEP_W-1:0]  count;
  logic               busy;
  logic               done;
  logic [RES_W:0]     trial;
  logic [RES_W-1:0]   rem_next;

  // One restoring step: double, bring in the next bit, subtract once if needed.
  always_comb begin
    trial = {residue, shreg[VALUE_W-1]};
    if (trial >= divisor) begin
      rem_next = RES_W'(trial - (RES_W + 1)'(divisor));
    end else begin
      rem_next = RES_W'(trial);
    end
  end

  // The sign bit weighs minus one, so it seeds the remainder with divisor - 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        shreg <= sum[VALUE_W-1:0];
        residue <= sum[VALUE_W] ? RES_W'(divisor - MOD_W'(1)) : '0;
      end else if (busy) begin
        residue <= rem_next;
        shreg   <= {shreg[VALUE_W-2:0], 1'b0};
        count   <= count + STEP_W'(1);
        if (count == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

@@ hdl/longest_subarray_sum_divisible.sv @@
// Top level of the longest run with sum divisible by a modulus.
//
// Each beat on the input carries one signed 32-bit value; the beat with last high closes
// the sequence and produces one result beat holding the length of the longest contiguous
// run whose sum is divisible by the modulus, and a flag for items dropped beyond the
// length limit. Before the next item is accepted, a reduced item is accepted, runs the 32
// steps of the bit-serial modulo unit, has its finished residue taken up, goes through the
// first-index table read and compare (skipped when the new residue is zero), and is closed.
// With a zero modulus, or for a dropped item, an item is accepted and then closed. The table
// lives in a RAM tagged with a sequence number; after reset, and after every 255 closed
// sequences, a clearing pass over all 1024 table entries runs during which no item is
// accepted. A result waits in an output register, and only a closing item stalls while an
// earlier result is still untaken.
`timescale 1ns / 1ps
`default_nettype none
`include "longest_subarray_sum_divisible_defines.svh"
module longest_subarray_sum_divisible
  import lsdiv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [MOD_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                 last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [LEN_W-1:0]     best_length,
  output logic                      too_long
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  logic [2:0]         state;
  logic [MOD_W-1:0]   modulus;
  logic [RES_W-1:0]   prefix_residue;
  logic [LEN_W-1:0]   position;
  logic [LEN_W-1:0]   best_so_far;
  logic               overflow_seen;
  logic [TAG_W-1:0]   epoch;
  logic [RES_W-1:0]   clr_addr;
  logic               item_last;
  logic               item_drop;

  logic [MOD_W-1:0]   k_eff;
  logic [VALUE_W:0]   sum;
  logic               red_start;
  lsdiv_red_status_t  red_status;
  logic [RES_W-1:0]   red_residue;

  logic               ram_we;
  logic [RES_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               entry_valid;
  logic [LEN_W-1:0]   run_len;
  logic               can_out;
  logic               accept;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_W'(1);
    end else if (cfg_wen) begin
      modulus <= cfg_wdata;
    end
  end

  // Divisor saturates at the table size.
  assign k_eff = (modulus > MOD_W'(RESIDUE_SLOTS)) ? MOD_W'(RESIDUE_SLOTS) : modulus;

  // Stored residue plus the new value, as a 33-bit two's complement word.
  assign sum = {value[VALUE_W-1], value} + (VALUE_W + 1)'(prefix_residue);

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign red_start = accept && (position < LEN_W'(MAX_LEN)) && (k_eff != '0);
  assign can_out   = !out_valid || out_ready;

  lsdiv_reducer u_reducer (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .sum     (sum),
    .divisor (k_eff),
    .status  (red_status),
    .residue (red_residue)
  );

  // Table port: clearing sweep, first-sight write, or lookup of a fresh residue.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = red_residue;
    ram_wdata = {epoch, position[FIRST_W-1:0]};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_CMP: begin
        ram_we   = !entry_valid;
        ram_addr = prefix_residue;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lsdiv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RESIDUE_SLOTS)
  ) u_first_index (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // An entry counts only when it was written during the current sequence.
  assign entry_valid = (ram_rdata[ENTRY_W-1:FIRST_W] == epoch);
  assign run_len     = position - LEN_W'(ram_rdata[FIRST_W-1:0]);

  // Sequencer for one item at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      epoch          <= TAG_W'(1);
      prefix_residue <= '0;
      position       <= '0;
      best_so_far    <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + RES_W'(1);
          if (clr_addr == RES_W'(RESIDUE_SLOTS - 1)) begin
            epoch <= TAG_W'(1);
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_last <= last;
            item_drop <= (position >= LEN_W'(MAX_LEN));
            if (position >= LEN_W'(MAX_LEN)) begin
              overflow_seen <= 1'b1;
              state         <= ST_FIN;
            end else if (k_eff == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (red_status.done) begin
            prefix_residue <= red_residue;
            if (red_residue == '0) begin
              if (position + LEN_W'(1) > best_so_far) begin
                best_so_far <= position + LEN_W'(1);
              end
              state <= ST_FIN;
            end else begin
              state <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (entry_valid && (run_len > best_so_far)) begin
            best_so_far <= run_len;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!item_last) begin
            if (!item_drop) begin
              position <= position + LEN_W'(1);
            end
            state <= ST_IDLE;
          end else if (can_out) begin
            prefix_residue <= '0;
            position       <= '0;
            best_so_far    <= '0;
            overflow_seen  <= 1'b0;
            if (epoch == TAG_MAX) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else begin
              epoch <= epoch + TAG_W'(1);
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a result beat is loaded when the closing item finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_FIN) && item_last && can_out) begin
        out_valid   <= 1'b1;
        best_length <= (modulus == '0) ? '0 : best_so_far;
        too_long    <= overflow_seen;
      end
    end
  end

  // An accepted item always starts work.
  `LSDIV_ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE)
  // The reduction unit reports only while the sequencer waits for it.
  `LSDIV_ASSERT_IMP(a_done_in_div, red_status.done, state == ST_DIV)
  // A result appears only when a closing item finishes.
  `LSDIV_ASSERT_IMP(a_result_from_close, $rose(out_valid),
                    $past(state) == ST_FIN && $past(item_last))
  // Between items no run can be longer than the items seen.
  `LSDIV_ASSERT_IMP(a_best_bounded, state == ST_IDLE, best_so_far <= position)

endmodule
`default_nettype wire
